FILE: design/nslf_pkg.sv
// Shared constants and types for the NMEA sentence line filter.
// No dependencies; imported by the filter, the checker and the testbench.
package nslf_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
   localparam int HEADER_LEN = 6;

   localparam logic [7:0]  CH_DOLLAR  = 8'h24;
   localparam logic [7:0]  CH_NEWLINE = 8'h0A;
   localparam logic [23:0] TYPE_RESET = 24'h474741;

   localparam logic KIND_LINE     = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EMIT = 3'b010,
      ST_NL   = 3'b100
   } state_type;

endpackage

FILE: design/nslf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module nslf_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/nmea_sentence_line_filter.sv
// NMEA sentence line filter top level: header check, line buffer control, output register.
// Depends on nslf_pkg and nslf_ram.
//
// Usage:
//   req_* carries received serial bytes, one per transaction. Bytes are stored in a
//   LINE_DEPTH-entry line RAM until a newline arrives. csr_* writes the expected
//   sentence type (three ASCII characters, first in the top byte); csr_ready is
//   always high, and writes are meant for times when the filter is idle.
//   rsp_* returns results: the bytes of an accepted line followed by the newline
//   (kind 0), or an overflow notice (kind 1, byte 0). rsp_last marks the final
//   result caused by one input byte.
// Result flow:
//   Data bytes are taken one per cycle while req_ready is high; an overflow notice shows
//   on rsp_* the cycle after the transaction. A newline that accepts a line of N bytes
//   (at most LINE_DEPTH - 2) streams them out of the line RAM through its read register
//   and the output register, one per cycle while rsp_ready is high, the newline last:
//   N + 1 results; the input is held off meanwhile. The single read port sets that rate.
// Reset: synchronous; clears the count, header flag, overflow flag, state and
//   output valid, and loads the sentence type "GGA". Line RAM contents stay as
//   they are: only positions written in the current line are read.
// Stall: results wait in the output register while rsp_ready is low; the drain
//   pauses and req_ready stays low until a pending result can be replaced.
module nmea_sentence_line_filter
   import nslf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_kind,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_sentence_type
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              header_good_ff, header_good_in;
   logic              ovf_rep_ff, ovf_rep_in;
   logic [23:0]       type_ff;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0] last_idx_ff, last_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              req_fire;
   logic              is_newline;
   logic [CNT_W-1:0]  count_inc;
   logic [7:0]        expected;
   logic              load;

   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   nslf_ram #(
      .DATA_W (8),
      .DEPTH  (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_valid && req_ready;
   assign is_newline = (req_rx_byte == CH_NEWLINE);
   assign count_inc  = count_ff + CNT_W'(1);
   assign csr_ready  = 1'b1;

   // header character expected at positions 3..5
   always_comb begin
      unique case (count_ff[1:0])
         2'd3:    expected = type_ff[23:16];
         2'd0:    expected = type_ff[15:8];
         2'd1:    expected = type_ff[7:0];
         default: expected = 8'h00;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      header_good_in = header_good_ff;
      ovf_rep_in     = ovf_rep_ff;
      rd_idx_in      = rd_idx_ff;
      last_idx_in    = last_idx_ff;
      load           = 1'b0;
      rsp_byte_in    = rsp_byte_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !is_newline) begin
               if (count_ff == '0) begin
                  header_good_in = (req_rx_byte == CH_DOLLAR);
               end else if (count_ff >= CNT_W'(3) && count_ff <= CNT_W'(5)) begin
                  header_good_in = header_good_ff && (req_rx_byte == expected);
               end
               if (count_ff < CNT_W'(LINE_DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_inc;
               end
               if (count_in >= CNT_W'(LINE_DEPTH) && !ovf_rep_ff) begin
                  load        = 1'b1;
                  rsp_byte_in = 8'h00;
                  rsp_kind_in = KIND_OVERFLOW;
                  rsp_last_in = 1'b1;
                  ovf_rep_in  = 1'b1;
               end
            end else if (req_fire) begin
               count_in       = '0;
               header_good_in = 1'b0;
               if (count_ff >= CNT_W'(LINE_DEPTH - 1)) begin
                  load        = 1'b1;
                  rsp_byte_in = 8'h00;
                  rsp_kind_in = KIND_OVERFLOW;
                  rsp_last_in = 1'b1;
               end else if (header_good_ff && count_ff >= CNT_W'(HEADER_LEN)) begin
                  // fetch position 0 now, drain one byte per cycle after while the output slot is free
                  ovf_rep_in  = 1'b0;
                  rd_en       = 1'b1;
                  rd_addr     = '0;
                  rd_idx_in   = '0;
                  last_idx_in = ADDR_W'(count_ff - CNT_W'(1));
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_byte_in = rd_data;
               rsp_kind_in = KIND_LINE;
               rsp_last_in = 1'b0;
               if (rd_idx_ff == last_idx_ff) begin
                  state_in = ST_NL;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_idx_ff + ADDR_W'(1);
                  rd_idx_in = rd_idx_ff + ADDR_W'(1);
               end
            end
         end
         ST_NL: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_byte_in = CH_NEWLINE;
               rsp_kind_in = KIND_LINE;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         header_good_ff <= 1'b0;
         ovf_rep_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         type_ff        <= TYPE_RESET;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         header_good_ff <= header_good_in;
         ovf_rep_ff     <= ovf_rep_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            type_ff <= csr_sentence_type;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: design/nslf_checker.sv
// Port-level checker for the NMEA sentence line filter, bound to the top level.
// Depends on nslf_pkg.
module nslf_checker
   import nslf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_kind,
   input logic       rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   // overflow notice is a single zero byte ending its transaction group
   a_ovf_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_OVERFLOW |-> rsp_out_byte == 8'h00 && rsp_last)
      else $error("malformed overflow notice");

   // an accepted line always ends on the newline
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LINE && rsp_last |-> rsp_out_byte == CH_NEWLINE)
      else $error("line does not end in newline");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind nmea_sentence_line_filter nslf_checker u_nslf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_kind     (rsp_kind),
   .rsp_last     (rsp_last)
);

FILE: test/nmea_sentence_line_filter_test.sv
// Self-checking testbench for nmea_sentence_line_filter: directed lines, then random lines.
// Depends on nslf_pkg and the filter RTL; results are predicted per accepted byte.
module nmea_sentence_line_filter_test;
   import nslf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 240;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic       last;
   } line_result_type;

   // How a directed row is checked: by the predictor, or by a typed-in outcome
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_QUIET,
      CHK_NOTICE
   } verdict_type;

   typedef struct {
      string       text;
      logic [7:0]  fill;
      int          reps;
      verdict_type mode;
   } drive_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_kind;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_sentence_type = 24'h000000;

   // Predictor state
   logic [7:0]  line_buf [LINE_DEPTH];
   int          fill_count = 0;
   bit          hdr_ok = 1'b0;
   bit          notice_sent = 1'b0;
   logic [23:0] type_sel = TYPE_RESET;

   line_result_type step_results [$];
   line_result_type due_results [$];

   int cycle_count = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int lines_sent = 0;
   int results_seen = 0;
   int notices_seen = 0;
   int cfg_writes = 0;
   int req_seg = 0;
   bit req_calm = 1'b0;
   int rsp_seg = 0;
   bit rsp_calm = 1'b0;

   drive_row_type plan [$] = '{
      '{"\n",         8'h00,  0, CHK_QUIET},   // empty line straight out of reset
      '{"$GPGGA\n",   8'h00,  0, CHK_MODEL},   // bare header, accepted
      '{"$GPGG\n",    8'h00,  0, CHK_QUIET},   // header cut short
      '{"#GPGGA,1\n", 8'h00,  0, CHK_QUIET},   // wrong start character
      '{"$GPXGA,1\n", 8'h00,  0, CHK_QUIET},
      '{"$GPGXA,1\n", 8'h00,  0, CHK_QUIET},
      '{"$GPGGX,1\n", 8'h00,  0, CHK_QUIET},
      '{"$",          8'h00,  1, CHK_MODEL},   // byte extremes inside a good line
      '{"",           8'hFF,  1, CHK_MODEL},
      '{"GGA,",       8'hFF,  2, CHK_MODEL},
      '{"\n",         8'h00,  0, CHK_MODEL},
      '{"$GPGGA",     8'hFF, 57, CHK_QUIET},   // one short of full
      '{"\n",         8'h00,  0, CHK_NOTICE},  // dropped at the newline
      '{"$GPGGA",     8'h78, 58, CHK_NOTICE},  // store fills on the last byte
      '{"",           8'h7A,  3, CHK_QUIET},   // no repeat notice mid-line
      '{"\n",         8'h00,  0, CHK_NOTICE},
      '{"$GPGGA,OK\n", 8'h00, 0, CHK_MODEL},   // good line clears the overflow flag
      '{"\n",         8'h00,  0, CHK_QUIET}
   };

   nmea_sentence_line_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_kind          (rsp_kind),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sentence_type (csr_sentence_type)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Busy stretches put a random idle gap before each transaction, calm stretches none
   function automatic int draw_gap(inout int seg_left, inout bit calm);
      if (seg_left == 0) begin
         seg_left = $urandom_range(8, 40);
         calm = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [7:0] pick_data_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
      return b;
   endfunction

   // Line filter prediction for one accepted byte; results land in step_results
   function automatic void screen_byte(input logic [7:0] b);
      step_results.delete();
      if (b != CH_NEWLINE) begin
         if (fill_count == 0)
            hdr_ok = (b == CH_DOLLAR);
         else if (fill_count >= 3 && fill_count <= 5)
            hdr_ok = hdr_ok && (b == type_sel[8 * (5 - fill_count) +: 8]);
         if (fill_count < LINE_DEPTH) begin
            line_buf[fill_count] = b;
            fill_count++;
         end
         if (fill_count >= LINE_DEPTH && !notice_sent) begin
            step_results.push_back('{8'h00, KIND_OVERFLOW, 1'b1});
            notice_sent = 1'b1;
         end
      end else begin
         if (fill_count + 1 >= LINE_DEPTH) begin
            step_results.push_back('{8'h00, KIND_OVERFLOW, 1'b1});
         end else if (hdr_ok && fill_count >= HEADER_LEN) begin
            for (int i = 0; i < fill_count; i++)
               step_results.push_back('{line_buf[i], KIND_LINE, 1'b0});
            step_results.push_back('{CH_NEWLINE, KIND_LINE, 1'b1});
            notice_sent = 1'b0;
         end
         fill_count = 0;
         hdr_ok = 1'b0;
      end
   endfunction

   function automatic void flag_mismatch(input string why, input line_result_type want,
                                         input line_result_type got);
      error_count++;
      if (error_count <= 10)
         $display("[%0t] %s: expected byte %h kind %0d last %0d, got byte %h kind %0d last %0d",
                  $time, why, want.out_byte, want.kind, want.last,
                  got.out_byte, got.kind, got.last);
   endfunction

   task automatic send_byte(input logic [7:0] b, input verdict_type mode,
                            input bit final_one);
      int gap;
      gap = draw_gap(req_seg, req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (b == CH_NEWLINE)
         lines_sent++;
      screen_byte(b);
      case (mode)
         CHK_MODEL: begin
            foreach (step_results[i])
               due_results.push_back(step_results[i]);
         end
         CHK_NOTICE: begin
            if (final_one)
               due_results.push_back('{8'h00, KIND_OVERFLOW, 1'b1});
         end
         default: begin
         end
      endcase
   endtask

   // Mostly well-formed sentences for the current type, plus broken and noise lines
   task automatic send_random_line();
      logic [7:0] head [6];
      logic [7:0] line_q [$];
      logic [7:0] x;
      int pick;
      int n;
      int spot;
      pick = $urandom_range(0, 9);
      head[0] = CH_DOLLAR;
      head[1] = pick_data_byte();
      head[2] = pick_data_byte();
      head[3] = type_sel[23:16];
      head[4] = type_sel[15:8];
      head[5] = type_sel[7:0];
      if (pick <= 7) begin
         if (pick == 7) begin
            spot = $urandom_range(2, 5);
            if (spot == 2)
               spot = 0;
            do x = pick_data_byte(); while (x == head[spot]);
            head[spot] = x;
         end
         foreach (head[i])
            line_q.push_back(head[i]);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 66) : $urandom_range(0, 12);
         repeat (n) line_q.push_back(pick_data_byte());
      end else if (pick == 8) begin
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++)
            line_q.push_back(head[i]);
      end else begin
         n = $urandom_range(1, 20);
         repeat (n)
            line_q.push_back(($urandom_range(0, 7) == 0) ? CH_NEWLINE : pick_data_byte());
      end
      line_q.push_back(CH_NEWLINE);
      foreach (line_q[i])
         send_byte(line_q[i], CHK_MODEL, 1'b0);
   endtask

   task automatic write_sentence_type(input logic [23:0] value);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      // a rejected line leaves no result behind; give the block time to settle
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_sentence_type <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      type_sel = value;
      cfg_writes++;
   endtask

   // Result side: random stalls, one long hold-off so the block backs up
   initial begin
      line_result_type got;
      line_result_type want;
      int gap;
      bit held;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(rsp_seg, rsp_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_out_byte, rsp_kind, rsp_last};
         results_seen++;
         if (got.kind == KIND_OVERFLOW)
            notices_seen++;
         if (due_results.size() == 0) begin
            flag_mismatch("result with nothing due", '0, got);
         end else begin
            want = due_results.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.last !== want.last)
               flag_mismatch("result mismatch", want, got);
         end
         if (!held && results_seen == 20) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin
      logic [23:0] type_plan [4];
      int total;
      int phase_start;
      type_plan[0] = 24'h000000;
      type_plan[1] = 24'hFFFFFF;
      type_plan[2] = {pick_data_byte(), pick_data_byte(), pick_data_byte()};
      type_plan[3] = TYPE_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         total = plan[r].text.len() + plan[r].reps;
         for (int k = 0; k < total; k++)
            send_byte((k < plan[r].text.len()) ? plan[r].text[k] : plan[r].fill,
                      plan[r].mode, k == total - 1);
      end

      foreach (type_plan[p]) begin
         write_sentence_type(type_plan[p]);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 12)
            send_random_line();
      end

      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (2 * LINE_DEPTH) @(posedge clock);

      $display("Sent %0d bytes in %0d lines over %0d sentence types written, %0d cycles",
               bytes_sent, lines_sent, cfg_writes, cycle_count);
      $display("Checked %0d results, %0d of them overflow notices; %0d mismatches",
               results_seen, notices_seen, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
